FILE: sv/bse_pkg.sv
// Shared types and constants for the beacon SSID extractor.
// Used by every module of the block; depends on nothing else.
package bse_pkg;

    localparam int POSITION_BITS_DEF = 12;

    // SSID store geometry is fixed by the element format
    localparam int MAX_SSID_BYTES = 32;
    localparam int SSID_IDX_W     = $clog2(MAX_SSID_BYTES);
    localparam int SSID_LEN_W     = $clog2(MAX_SSID_BYTES + 1);

    // frame descriptor queue between the parser and the emitter
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam int BSSID_W     = 48;
    localparam int BSSID_FIRST = 16;
    localparam int BSSID_LAST  = 21;

    localparam int IE_OFF_W       = 7;
    localparam int MIN_LEN_W      = 8;
    localparam int IE_START_RESET = 36;
    localparam int MIN_LEN_RESET  = 40;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_IE_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN  = 2'd1;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [BSSID_W-1:0]    bssid;
        logic signed [7:0]     rssi;
        logic [SSID_LEN_W-1:0] ssid_len;   // zero when no SSID was kept
    } t_frame_desc;

    typedef struct packed {
        logic                  en;
        logic [SSID_IDX_W-1:0] idx;
        logic [7:0]            data;
    } t_ssid_wr;

    typedef struct packed {
        logic                  en;
        logic [SSID_IDX_W-1:0] idx;
    } t_ssid_rd;

endpackage

FILE: sv/bse_front.sv
// Front end: byte parser that captures the BSSID and walks information elements.
// Writes SSID bytes into the queue's store and pushes one descriptor per kept frame.
// Depends on bse_pkg.
module bse_front
    import bse_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg_wr            i_cfg,
    input  logic               i_accept,
    input  logic [7:0]         i_frame_byte,
    input  logic               i_last_byte,
    input  logic signed [7:0]  i_signal_strength,
    output t_ssid_wr           o_wr,
    output logic               o_push,
    output t_frame_desc        o_desc
);

    localparam int LEN_W = POSITION_BITS + 1;

    localparam logic [1:0] PH_TYPE = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    logic [IE_OFF_W-1:0]      r_ie_start;
    logic [MIN_LEN_W-1:0]     r_min_len;

    logic [POSITION_BITS-1:0] r_pos,      n_pos;
    logic [BSSID_W-1:0]       r_bssid,    n_bssid;
    logic [1:0]               r_phase,    n_phase;
    logic [7:0]               r_type,     n_type;
    logic [7:0]               r_rem,      n_rem;
    logic                     r_is_ssid,  n_is_ssid;
    logic [SSID_LEN_W-1:0]    r_count,    n_count;
    logic                     r_complete, n_complete;

    logic                     walk_en;
    logic                     in_bssid;
    logic [LEN_W-1:0]         frame_len;
    logic                     too_short;

    assign in_bssid  = (r_pos >= POSITION_BITS'(BSSID_FIRST))
                    && (r_pos <= POSITION_BITS'(BSSID_LAST));
    assign walk_en   = (r_pos >= POSITION_BITS'(r_ie_start)) && !r_complete;
    assign frame_len = LEN_W'(r_pos) + LEN_W'(1);
    assign too_short = frame_len < LEN_W'(r_min_len);

    always_comb begin
        n_pos      = r_pos;
        n_bssid    = r_bssid;
        n_phase    = r_phase;
        n_type     = r_type;
        n_rem      = r_rem;
        n_is_ssid  = r_is_ssid;
        n_count    = r_count;
        n_complete = r_complete;
        o_wr       = '0;
        o_push     = 1'b0;
        o_desc     = '0;

        if (i_accept) begin
            if (in_bssid) begin
                n_bssid = {r_bssid[BSSID_W-9:0], i_frame_byte};
            end
            if (walk_en) begin
                unique case (r_phase)
                    PH_TYPE: begin
                        n_type  = i_frame_byte;
                        n_phase = PH_LEN;
                    end
                    PH_LEN: begin
                        n_rem     = i_frame_byte;
                        n_is_ssid = (r_type == 8'd0) && (i_frame_byte != 8'd0)
                                 && (i_frame_byte <= 8'(MAX_SSID_BYTES));
                        if (n_is_ssid) begin
                            n_count = '0;
                        end
                        n_phase = (i_frame_byte == 8'd0) ? PH_TYPE : PH_BODY;
                    end
                    default: begin
                        if (r_is_ssid) begin
                            o_wr.en   = 1'b1;
                            o_wr.idx  = r_count[SSID_IDX_W-1:0];
                            o_wr.data = i_frame_byte;
                            n_count   = r_count + SSID_LEN_W'(1);
                        end
                        n_rem = r_rem - 8'd1;
                        if (n_rem == 8'd0) begin
                            if (r_is_ssid) begin
                                n_complete = 1'b1;
                            end
                            n_phase = PH_TYPE;
                        end
                    end
                endcase
            end
            // saturate rather than wrap on oversize frames
            if (r_pos != '1) begin
                n_pos = r_pos + POSITION_BITS'(1);
            end

            if (i_last_byte) begin
                o_push        = !too_short;
                o_desc.bssid  = n_bssid;
                o_desc.rssi   = i_signal_strength;
                if (!n_complete) begin
                    o_desc.ssid_len = '0;
                end else if (n_count > SSID_LEN_W'(MAX_SSID_BYTES)) begin
                    o_desc.ssid_len = SSID_LEN_W'(MAX_SSID_BYTES);
                end else begin
                    o_desc.ssid_len = n_count;
                end
                // start the next frame from a clean slate
                n_pos      = '0;
                n_bssid    = '0;
                n_phase    = PH_TYPE;
                n_type     = '0;
                n_rem      = '0;
                n_is_ssid  = 1'b0;
                n_count    = '0;
                n_complete = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ie_start <= IE_OFF_W'(IE_START_RESET);
            r_min_len  <= MIN_LEN_W'(MIN_LEN_RESET);
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_IE_START) begin
                r_ie_start <= i_cfg.data[IE_OFF_W-1:0];
            end else if (i_cfg.index == CFG_MIN_LEN) begin
                r_min_len <= i_cfg.data[MIN_LEN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_bssid    <= '0;
            r_phase    <= PH_TYPE;
            r_type     <= '0;
            r_rem      <= '0;
            r_is_ssid  <= 1'b0;
            r_count    <= '0;
            r_complete <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_bssid    <= n_bssid;
            r_phase    <= n_phase;
            r_type     <= n_type;
            r_rem      <= n_rem;
            r_is_ssid  <= n_is_ssid;
            r_count    <= n_count;
            r_complete <= n_complete;
        end
    end

endmodule

FILE: sv/bse_queue.sv
// Frame queue: descriptor slots plus one SSID store bank per slot.
// The parser fills the tail bank while the emitter reads the head bank. Depends on bse_pkg.
module bse_queue
    import bse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ssid_wr    i_wr,
    input  logic        i_push,
    input  t_frame_desc i_desc,
    input  t_ssid_rd    i_rd,
    input  logic        i_pop,
    output logic        o_full,
    output logic        o_empty,
    output t_frame_desc o_head,
    output logic [7:0]  o_rd_data
);

    localparam int MEM_DEPTH = Q_DEPTH * MAX_SSID_BYTES;

    logic [7:0]        r_mem [MEM_DEPTH];
    t_frame_desc       r_desc [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic [7:0]        r_rd_data;

    assign o_full    = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_head    = r_desc[r_rd_ptr];
    assign o_rd_data = r_rd_data;

    // the tail bank is free for the whole frame, so reads and writes never share a bank
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[{r_wr_ptr, i_wr.idx}] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[{r_rd_ptr, i_rd.idx}];
        end
        if (i_push) begin
            r_desc[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

endmodule

FILE: sv/bse_back.sv
// Back end: emits the head frame as a run of results, one SSID byte per transaction.
// Owns the output register; the SSID byte comes from the queue's read data register.
// Depends on bse_pkg.
module bse_back
    import bse_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  t_frame_desc           i_head,
    input  logic [7:0]            i_rd_data,
    output t_ssid_rd              o_rd,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [BSSID_W-1:0]    o_bssid,
    output logic signed [7:0]     o_rssi_out,
    output logic                  o_ssid_found,
    output logic [SSID_LEN_W-1:0] o_ssid_length,
    output logic [SSID_IDX_W-1:0] o_ssid_index,
    output logic [7:0]            o_ssid_char,
    output logic                  o_run_last
);

    logic                  r_valid;
    logic [BSSID_W-1:0]    r_bssid;
    logic signed [7:0]     r_rssi;
    logic                  r_found;
    logic [SSID_LEN_W-1:0] r_length;
    logic [SSID_IDX_W-1:0] r_index;
    logic                  r_last;
    logic [SSID_IDX_W-1:0] r_k;

    logic                  load;
    logic                  take;
    logic                  found;
    logic                  last;

    assign load  = !r_valid || !i_out_stall;
    assign take  = load && !i_empty;
    assign found = (i_head.ssid_len != '0);
    assign last  = !found || ((SSID_LEN_W'(r_k) + SSID_LEN_W'(1)) == i_head.ssid_len);

    assign o_rd.en  = take && found;
    assign o_rd.idx = r_k;
    assign o_pop    = take && last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bssid  <= i_head.bssid;
            r_rssi   <= i_head.rssi;
            r_found  <= found;
            r_length <= i_head.ssid_len;
            r_index  <= found ? r_k : '0;
            r_last   <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_k     <= '0;
        end else begin
            if (load) begin
                r_valid <= !i_empty;
            end
            // advance through the SSID, rewind once the run is handed off
            if (take) begin
                r_k <= last ? '0 : r_k + SSID_IDX_W'(1);
            end
        end
    end

    assign o_out_valid   = r_valid;
    assign o_bssid       = r_bssid;
    assign o_rssi_out    = r_rssi;
    assign o_ssid_found  = r_found;
    assign o_ssid_length = r_length;
    assign o_ssid_index  = r_index;
    assign o_ssid_char   = r_found ? i_rd_data : 8'd0;
    assign o_run_last    = r_last;

endmodule

FILE: sv/beacon_ssid_extractor.sv
// Beacon SSID extractor top level: parser front end, frame queue, result emitter.
// Depends on bse_pkg, bse_front, bse_queue and bse_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one frame byte per transaction,
//   with i_last_byte on the final byte and i_signal_strength sampled there.
//   Output channel (o_out_valid / i_out_stall) gives one transaction per SSID byte,
//   o_run_last on the last, or a single transaction with o_ssid_found low.
//   Frames shorter than min_frame_len give no transaction at all.
//   Configuration: i_cfg_valid with i_cfg_index / i_cfg_data; o_cfg_ready is always
//   high. Index 0 sets ie_start_offset, index 1 sets min_frame_len.
// Timing:
//   One byte accepted per cycle unless stalled. A frame's first result is loaded
//   into the output register after its descriptor enters an empty queue; a run
//   of n SSID bytes then drains at one result per cycle unless stalled. The queue
//   holds two finished frames; o_in_stall is high while both wait, until the head
//   is popped. A stalled result holds until taken; bytes flow if there is room.
// Reset: i_rst_n (synchronous, active low) empties the queue, restarts frame parsing
//   and loads the register reset values.
module beacon_ssid_extractor
    import bse_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_frame_byte,
    input  logic                  i_last_byte,
    input  logic signed [7:0]     i_signal_strength,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [BSSID_W-1:0]    o_bssid,
    output logic signed [7:0]     o_rssi_out,
    output logic                  o_ssid_found,
    output logic [SSID_LEN_W-1:0] o_ssid_length,
    output logic [SSID_IDX_W-1:0] o_ssid_index,
    output logic [7:0]            o_ssid_char,
    output logic                  o_run_last
);

    t_cfg_wr     cfg;
    t_ssid_wr    ssid_wr;
    t_ssid_rd    ssid_rd;
    t_frame_desc push_desc;
    t_frame_desc head_desc;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    logic        in_accept;
    logic [7:0]  rd_data;

    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    bse_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_accept          (in_accept),
        .i_frame_byte      (i_frame_byte),
        .i_last_byte       (i_last_byte),
        .i_signal_strength (i_signal_strength),
        .o_wr              (ssid_wr),
        .o_push            (push),
        .o_desc            (push_desc)
    );

    bse_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (ssid_wr),
        .i_push    (push),
        .i_desc    (push_desc),
        .i_rd      (ssid_rd),
        .i_pop     (pop),
        .o_full    (q_full),
        .o_empty   (q_empty),
        .o_head    (head_desc),
        .o_rd_data (rd_data)
    );

    bse_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .i_head        (head_desc),
        .i_rd_data     (rd_data),
        .o_rd          (ssid_rd),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_bssid       (o_bssid),
        .o_rssi_out    (o_rssi_out),
        .o_ssid_found  (o_ssid_found),
        .o_ssid_length (o_ssid_length),
        .o_ssid_index  (o_ssid_index),
        .o_ssid_char   (o_ssid_char),
        .o_run_last    (o_run_last)
    );

endmodule

FILE: sv/bse_checker.sv
// Port-level checker for the beacon SSID extractor, bound to the top level.
// Depends on bse_pkg and beacon_ssid_extractor.
module bse_checker
    import bse_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [BSSID_W-1:0]    o_bssid,
    input logic                  o_ssid_found,
    input logic [SSID_LEN_W-1:0] o_ssid_length,
    input logic [SSID_IDX_W-1:0] o_ssid_index,
    input logic [7:0]            o_ssid_char,
    input logic                  o_run_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_bssid)
            && $stable(o_ssid_index) && $stable(o_ssid_char) && $stable(o_run_last))
        else $error("stalled result changed");

    // a frame without SSID is a single, empty result
    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ssid_found |-> o_run_last && o_ssid_length == '0
            && o_ssid_index == '0 && o_ssid_char == 8'd0)
        else $error("not-found result malformed");

    // run end lines up with the SSID length
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ssid_found |-> o_ssid_length != '0
            && (o_run_last == ((SSID_LEN_W'(o_ssid_index) + SSID_LEN_W'(1)) == o_ssid_length)))
        else $error("run_last does not match SSID length");

    // a run continues in the next cycle with the next index of the same frame
    a_run_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_run_last |=> o_out_valid
            && o_ssid_index == $past(o_ssid_index) + SSID_IDX_W'(1)
            && o_bssid == $past(o_bssid))
        else $error("SSID run broken");

endmodule

bind beacon_ssid_extractor bse_checker u_bse_checker (.*);

FILE: bench/tb_beacon_ssid_extractor.sv
`timescale 1ns / 1ps
// Self-checking bench for beacon_ssid_extractor: beacon frames byte by byte in, SSID runs out.
// Depends on bse_pkg and the beacon_ssid_extractor RTL; holds its own model of the parser.
module tb_beacon_ssid_extractor;
    import bse_pkg::*;

    localparam int POS_BITS = POSITION_BITS_DEF;
    localparam logic [7:0] IE_SSID = 8'd0;
    localparam logic [7:0] IE_VENDOR = 8'd221;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BYTES = 30;

    typedef enum logic [1:0] {EXPECT_TYPE, EXPECT_LEN, IN_BODY} t_ie_phase;

    typedef struct {
        logic [BSSID_W-1:0]    bssid;
        logic signed [7:0]     rssi;
        logic                  found;
        logic [SSID_LEN_W-1:0] len;
        logic [SSID_IDX_W-1:0] idx;
        logic [7:0]            ch;
        logic                  last;
    } t_ssid_row;

    // Tracks the parser state per frame and the SSID rows still owed by the block.
    class t_ssid_tracker;
        logic [IE_OFF_W-1:0]  ie_start;
        logic [MIN_LEN_W-1:0] min_len;
        logic [POS_BITS-1:0]  pos;
        logic [BSSID_W-1:0]   bssid;
        t_ie_phase            phase;
        logic [7:0]           ie_type;
        logic [7:0]           remaining;
        logic                 is_ssid;
        logic                 complete;
        logic [7:0]           store [MAX_SSID_BYTES];
        logic [5:0]           count;
        t_ssid_row            rows_due[$];
        int n_frames, n_dropped, n_named, n_rows, n_errors;

        function new();
            ie_start = IE_OFF_W'(IE_START_RESET);
            min_len = MIN_LEN_W'(MIN_LEN_RESET);
            clear_frame();
        endfunction

        function void clear_frame();
            pos = '0;
            bssid = '0;
            phase = EXPECT_TYPE;
            ie_type = '0;
            remaining = '0;
            is_ssid = 1'b0;
            count = '0;
            complete = 1'b0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            unique case (idx)
                CFG_IE_START: ie_start = data[IE_OFF_W-1:0];
                CFG_MIN_LEN:  min_len = data[MIN_LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function void walk(logic [7:0] b);
            unique case (phase)
                EXPECT_TYPE: begin
                    ie_type = b;
                    phase = EXPECT_LEN;
                end
                EXPECT_LEN: begin
                    remaining = b;
                    is_ssid = (ie_type == IE_SSID) && (b >= 1) && (b <= MAX_SSID_BYTES);
                    if (is_ssid) count = '0;
                    phase = (b == 0) ? EXPECT_TYPE : IN_BODY;
                end
                default: begin
                    if (is_ssid) begin
                        store[count[SSID_IDX_W-1:0]] = b;
                        count = count + 1'b1;
                    end
                    remaining = remaining - 1'b1;
                    if (remaining == 0) begin
                        if (is_ssid) complete = 1'b1;
                        phase = EXPECT_TYPE;
                    end
                end
            endcase
        endfunction

        // Advance on one accepted input transaction; queue the rows a finished frame owes.
        function void note_byte(logic [7:0] b, logic last, logic [7:0] rssi);
            logic [POS_BITS-1:0] at;
            int n;
            t_ssid_row row;
            at = pos;
            if (at >= BSSID_FIRST && at <= BSSID_LAST) bssid = {bssid[BSSID_W-9:0], b};
            if (at >= ie_start && !complete) walk(b);
            if (at != '1) pos = pos + 1'b1;
            if (!last) return;
            n_frames++;
            if (int'(at) + 1 < int'(min_len)) begin
                n_dropped++;
                clear_frame();
                return;
            end
            n = complete ? int'(count) : 0;
            row.bssid = bssid;
            row.rssi = rssi;
            if (n == 0) begin
                row.found = 1'b0;
                row.len = '0;
                row.idx = '0;
                row.ch = '0;
                row.last = 1'b1;
                rows_due.insert(rows_due.size(), row);
            end else begin
                n_named++;
                for (int k = 0; k < n; k++) begin
                    row.found = 1'b1;
                    row.len = SSID_LEN_W'(n);
                    row.idx = SSID_IDX_W'(k);
                    row.ch = store[k];
                    row.last = (k == n - 1);
                    rows_due.insert(rows_due.size(), row);
                end
            end
            clear_frame();
        endfunction

        function void check_row(t_ssid_row got);
            t_ssid_row want;
            n_rows++;
            if (rows_due.size() == 0) begin
                $error("unexpected result: bssid %h ssid_index %0d", got.bssid, got.idx);
                n_errors++;
                return;
            end
            want = rows_due.pop_front();
            if (got.bssid !== want.bssid) begin
                $error("bssid: expected %h, got %h", want.bssid, got.bssid);
                n_errors++;
            end
            if (got.rssi !== want.rssi) begin
                $error("rssi_out: expected %0d, got %0d", want.rssi, got.rssi);
                n_errors++;
            end
            if (got.found !== want.found) begin
                $error("ssid_found: expected %b, got %b", want.found, got.found);
                n_errors++;
            end
            if (got.len !== want.len) begin
                $error("ssid_length: expected %0d, got %0d", want.len, got.len);
                n_errors++;
            end
            if (got.idx !== want.idx) begin
                $error("ssid_index: expected %0d, got %0d", want.idx, got.idx);
                n_errors++;
            end
            if (got.ch !== want.ch) begin
                $error("ssid_char: expected %h, got %h", want.ch, got.ch);
                n_errors++;
            end
            if (got.last !== want.last) begin
                $error("run_last: expected %b, got %b", want.last, got.last);
                n_errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [7:0]            i_frame_byte = '0;
    logic                  i_last_byte = 1'b0;
    logic signed [7:0]     i_signal_strength = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [BSSID_W-1:0]    o_bssid;
    logic signed [7:0]     o_rssi_out;
    logic                  o_ssid_found;
    logic [SSID_LEN_W-1:0] o_ssid_length;
    logic [SSID_IDX_W-1:0] o_ssid_index;
    logic [7:0]            o_ssid_char;
    logic                  o_run_last;

    t_ssid_tracker tracker = new();
    logic [7:0] frame_buf[$];
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int n_bytes = 0;

    beacon_ssid_extractor dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_frame_byte      (i_frame_byte),
        .i_last_byte       (i_last_byte),
        .i_signal_strength (i_signal_strength),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_bssid           (o_bssid),
        .o_rssi_out        (o_rssi_out),
        .o_ssid_found      (o_ssid_found),
        .o_ssid_length     (o_ssid_length),
        .o_ssid_index      (o_ssid_index),
        .o_ssid_char       (o_ssid_char),
        .o_run_last        (o_run_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    // Sample results with pre-edge values, then pick the stall for the next cycle.
    always @(posedge i_clk) begin : out_monitor
        t_ssid_row seen;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.bssid = o_bssid;
            seen.rssi = o_rssi_out;
            seen.found = o_ssid_found;
            seen.len = o_ssid_length;
            seen.idx = o_ssid_index;
            seen.ch = o_ssid_char;
            seen.last = o_run_last;
            tracker.check_row(seen);
        end
        i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    function automatic void add_byte(logic [7:0] value);
        frame_buf.insert(frame_buf.size(), value);
    endfunction

    function automatic void add_random(int n);
        repeat (n) add_byte(8'($urandom));
    endfunction

    function automatic void add_fill(logic [7:0] value, int n);
        repeat (n) add_byte(value);
    endfunction

    function automatic void add_element(logic [7:0] kind, int len);
        add_byte(kind);
        add_byte(8'(len));
        add_random(len);
    endfunction

    function automatic void pad_to(int n);
        while (frame_buf.size() < n) add_byte(8'($urandom));
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic last, input logic [7:0] rssi);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
        i_in_valid <= 1'b1;
        i_frame_byte <= b;
        i_last_byte <= last;
        i_signal_strength <= rssi;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_byte(b, last, rssi);
        n_bytes++;
    endtask

    task automatic send_frame(input logic [7:0] rssi);
        int n;
        if (frame_buf.size() == 0) add_byte(8'($urandom));
        n = frame_buf.size();
        for (int i = 0; i < n; i++)
            push_byte(frame_buf[i], i == n - 1, (i == n - 1) ? rssi : 8'($urandom));
        frame_buf.delete();
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        while (tracker.rows_due.size() != 0) @(posedge i_clk);
    endtask

    // Dropped frames leave nothing to wait on, so let the parser settle after draining.
    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_reg(idx, data);
    endtask

    task automatic configure(input logic [7:0] ie_start, input logic [7:0] min_len);
        settle();
        write_reg(CFG_IE_START, ie_start);
        write_reg(CFG_MIN_LEN, min_len);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed beacons with random content; some noise, bogus and cut-off SSIDs.
    function automatic void build_random_frame();
        int hdr, kind, cut, target;
        hdr = int'(tracker.ie_start);
        kind = $urandom_range(9);
        if (kind < 2) begin
            add_random($urandom_range(1, hdr + 24));
            return;
        end
        add_random(hdr);
        repeat ($urandom_range(2))
            add_element(8'($urandom_range(1, 255)), $urandom_range(0, 6));
        if (kind == 2)
            add_element(IE_SSID, $urandom_range(1) ? 0 : $urandom_range(33, 40));
        if (kind != 3)
            add_element(IE_SSID, ($urandom_range(9) == 0) ? 32 : $urandom_range(1, 8));
        if (kind == 4) begin
            cut = $urandom_range(hdr + 1, frame_buf.size() - 1);
            while (frame_buf.size() > cut) void'(frame_buf.pop_back());
            return;
        end
        if ($urandom_range(7) == 0)
            target = int'(tracker.min_len) - int'($urandom_range(1, 3));
        else
            target = int'(tracker.min_len) + int'($urandom_range(0, 6));
        pad_to(target);
    endfunction

    task automatic random_configure();
        logic [7:0] ie_start, min_len;
        int pick;
        ie_start = ($urandom_range(9) == 0) ? 8'($urandom_range(0, 23))
                                            : 8'($urandom_range(24, 32));
        pick = $urandom_range(19);
        if (pick < 16)
            min_len = 8'($urandom_range(24, 40));
        else
            min_len = 8'($urandom_range(0, 23));
        configure(ie_start, min_len);
    endtask

    initial begin
        int b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset register values: elements at 36, minimum length 40.
        // BSSID all ones, shortest SSID, weakest signal
        add_random(16); add_fill(8'hFF, 6); add_random(14);
        add_element(IE_SSID, 1); pad_to(40);
        send_frame(8'h80);
        // SSID body cut off by the frame end, frame exactly at the minimum length
        add_random(36); add_byte(IE_SSID); add_byte(8'd10); add_random(2);
        send_frame(8'($urandom));

        configure(8'd24, 8'd24);
        // BSSID all zeros, longest SSID of all-ones characters, strongest signal
        add_random(16); add_fill(8'h00, 6); add_random(2);
        add_byte(IE_SSID); add_byte(8'd32); add_fill(8'hFF, 32);
        send_frame(8'h7F);
        // vendor element first, zero-length and oversize SSIDs skipped,
        // the next one kept and a later SSID ignored
        add_random(24); add_element(IE_VENDOR, 2);
        add_element(IE_SSID, 0); add_element(IE_SSID, 33);
        add_byte(IE_SSID); add_byte(8'd3); add_fill(8'h00, 3);
        add_element(IE_SSID, 4);
        send_frame(8'($urandom));
        // header only, exactly the minimum length
        add_random(24);
        send_frame(8'($urandom));
        // one byte short of the minimum: dropped
        add_random(23);
        send_frame(8'($urandom));
        // single-byte frame: dropped
        add_random(1);
        send_frame(8'($urandom));

        // unused index, offset masked to its width, no minimum length
        settle();
        write_reg(CFG_SPARE, 8'h5A);
        write_reg(CFG_IE_START, 8'hA4);
        write_reg(CFG_MIN_LEN, 8'h00);
        i_cfg_valid <= 1'b0;
        add_random(1);
        send_frame(8'($urandom));
        add_random(36); add_element(IE_SSID, 2);
        send_frame(8'($urandom));

        // walk from byte zero, frame ends inside the BSSID
        configure(8'd0, 8'd10);
        add_element(IE_SSID, 3); add_random(14);
        send_frame(8'($urandom));

        for (int ph = 0; ph < 3; ph++) begin
            gap_pct = (ph == 0) ? 26 : (ph == 1) ? 82 : 0;
            stall_pct = (ph == 0) ? 82 : (ph == 1) ? 26 : 0;
            random_configure();
            b0 = n_bytes;
            while (n_bytes - b0 < PHASE_BYTES) begin
                if ($urandom_range(5) == 0)
                    random_configure();
                else if ($urandom_range(7) == 0)
                    hold_until_drained();
                build_random_frame();
                send_frame(8'($urandom));
            end
        end

        hold_until_drained();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d bytes in %0d frames (%0d dropped, %0d with an SSID).",
                 n_bytes, tracker.n_frames, tracker.n_dropped, tracker.n_named);
        $display("Checked %0d results across several offset and length settings.",
                 tracker.n_rows);
        if (tracker.n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: beacon_ssid_extractor.f
sv/bse_pkg.sv
sv/bse_front.sv
sv/bse_queue.sv
sv/bse_back.sv
sv/beacon_ssid_extractor.sv
sv/bse_checker.sv
bench/tb_beacon_ssid_extractor.sv
